/* hdl/rau_pkg.sv */
// shared types and constants for the rational arithmetic unit
package rau_pkg;

  localparam int OperandWidthDefault = 32;

  typedef enum logic [2:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_MUL = 3'd2,
    ACT_DIV = 3'd3,
    ACT_CMP = 3'd4
  } action_t;

  // sequencer states of the top level
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_A,
    ST_WAIT_A,
    ST_RED_B,
    ST_WAIT_B,
    ST_MUL1,
    ST_MUL2,
    ST_FORM,
    ST_RED_R,
    ST_WAIT_R,
    ST_OUT
  } state_t;

  // divider unit states
  typedef enum logic [2:0] {
    DV_IDLE,
    DV_GCD,
    DV_QN,
    DV_QD,
    DV_DONE
  } dv_state_t;

  typedef struct packed {
    logic start;
  } red_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } red_sts_t;

endpackage

/* hdl/rau_reduce.sv */
// reduces a magnitude pair to lowest terms with one shared restoring divider
module rau_reduce (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rau_pkg::red_ctl_t    ctl,
  input  logic [63:0]          x_in,
  input  logic [63:0]          y_in,
  output rau_pkg::red_sts_t    sts,
  output logic [63:0]          x_out,
  output logic [63:0]          y_out
);
  import rau_pkg::*;

  dv_state_t   st_r, st_nxt;
  logic [63:0] x_r, y_r;        // original values
  logic [63:0] ga_r, gb_r;      // euclid pair
  logic [63:0] dvd_r, rem_r, quo_r;
  logic [63:0] dvs_r;
  logic [6:0]  cnt_r;
  logic [63:0] qn_r;
  logic [64:0] trial;
  logic [63:0] rem_sh;
  logic        div_last;

  assign rem_sh   = {rem_r[62:0], dvd_r[63]};
  assign trial    = {1'b0, rem_sh} - {1'b0, dvs_r};
  assign div_last = (cnt_r == 7'd63);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      DV_IDLE: if (ctl.start) st_nxt = DV_GCD;
      DV_GCD:  if (gb_r == 64'd0) st_nxt = DV_QN;
               else if (div_last) st_nxt = DV_GCD;
      DV_QN:   if (div_last) st_nxt = DV_QD;
      DV_QD:   if (div_last) st_nxt = DV_DONE;
      DV_DONE: st_nxt = DV_IDLE;
      default: st_nxt = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= DV_IDLE;
      cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      unique case (st_r)
        DV_IDLE: begin
          cnt_r <= '0;
          if (ctl.start) begin
            x_r <= x_in;  y_r <= y_in;
            ga_r <= x_in; gb_r <= y_in;
            dvd_r <= x_in; dvs_r <= y_in; rem_r <= '0;
          end
        end
        DV_GCD, DV_QN, DV_QD: begin
          if (st_r == DV_GCD && gb_r == 64'd0) begin
            // gcd found in ga, start quotient x / g
            cnt_r <= '0; dvd_r <= x_r; dvs_r <= ga_r; rem_r <= '0;
          end else begin
            dvd_r <= {dvd_r[62:0], ~trial[64]};
            rem_r <= trial[64] ? rem_sh : trial[63:0];
            cnt_r <= cnt_r + 7'd1;
            if (div_last) begin
              cnt_r <= '0;
              rem_r <= '0;
              quo_r <= {dvd_r[62:0], ~trial[64]};
              if (st_r == DV_GCD) begin
                ga_r <= gb_r;
                gb_r <= trial[64] ? rem_sh : trial[63:0];
                dvd_r <= gb_r;
                dvs_r <= trial[64] ? rem_sh : trial[63:0];
              end else if (st_r == DV_QN) begin
                qn_r  <= {dvd_r[62:0], ~trial[64]};
                dvd_r <= y_r;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign sts.busy = (st_r != DV_IDLE);
  assign sts.done = (st_r == DV_DONE);
  assign x_out    = qn_r;
  assign y_out    = quo_r;
endmodule

/* hdl/rational_arithmetic_unit.sv */
// rational arithmetic unit: top level with sequencer and shared multiplier
// reductions are skipped for zero values; each other one runs the 64-step restoring divider per euclid step
// throughput: one beat at a time, in_stall high while busy or a result waits
// reset (synchronous, rst_n low) returns the sequencer to idle and drops
// out_valid; payload registers are not cleared
module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = rau_pkg::OperandWidthDefault
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                in_action,
  input  logic signed [31:0]        in_a_num,
  input  logic signed [31:0]        in_a_den,
  input  logic signed [31:0]        in_b_num,
  input  logic signed [31:0]        in_b_den,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [63:0]        out_res_num,
  output logic [61:0]               out_res_den,
  output logic                      out_is_less,
  output logic                      out_is_equal,
  output logic                      out_is_greater
);
  import rau_pkg::*;

  localparam int W = OPERAND_WIDTH;

  state_t      st_r, st_nxt;
  logic [2:0]  act_r;
  logic [63:0] an_r, ad_r, bn_r, bd_r;   // magnitudes
  logic        as_r, bs_r;               // operand signs (numerator sign xor denominator sign)
  logic [63:0] p0_r, p1_r, p2_r;
  logic        rs_r;
  logic [63:0] rn_r, rd_r;
  logic        lt_r, eq_r, gt_r;
  logic        out_valid_r;

  red_ctl_t    rctl;
  red_sts_t    rsts;
  logic [63:0] rx, ry, qx, qy;

  // saturated magnitude of a raw operand of width W
  function automatic logic [63:0] op_mag(input logic [31:0] raw);
    logic [W-1:0] v;
    logic [W-1:0] m;
    v = raw[W-1:0];
    m = v[W-1] ? (~v + 1'b1) : v;
    if (m[W-1]) m = {1'b0, {(W-1){1'b1}}};
    return {{(64-W){1'b0}}, m};
  endfunction

  // shared multiplier, 32x32 of magnitudes
  logic [31:0] ma, mb;
  logic [63:0] mp;
  assign mp = ma * mb;

  always_comb begin
    ma = '0; mb = '0;
    unique case (st_r)
      ST_MUL1: begin
        ma = an_r[31:0];
        mb = (act_r == ACT_MUL) ? bn_r[31:0] : bd_r[31:0];
      end
      ST_MUL2: begin
        ma = ad_r[31:0];
        mb = (act_r == ACT_DIV) ? bn_r[31:0] : bn_r[31:0];
      end
      ST_FORM: begin
        ma = ad_r[31:0];
        mb = bd_r[31:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:   if (in_valid) st_nxt = ST_RED_A;
      ST_RED_A:  st_nxt = (an_r == 0) ? ST_RED_B : ST_WAIT_A;
      ST_WAIT_A: if (rsts.done) st_nxt = ST_RED_B;
      ST_RED_B:  st_nxt = (bn_r == 0) ? ST_MUL1 : ST_WAIT_B;
      ST_WAIT_B: if (rsts.done) st_nxt = ST_MUL1;
      ST_MUL1:   st_nxt = ST_MUL2;
      ST_MUL2:   st_nxt = ST_FORM;
      ST_FORM:   st_nxt = ST_RED_R;
      ST_RED_R:  st_nxt = (rn_r == 0 || rd_r == 0) ? ST_OUT : ST_WAIT_R;
      ST_WAIT_R: if (rsts.done) st_nxt = ST_OUT;
      ST_OUT:    if (!out_stall) st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    rctl.start = 1'b0;
    rx = '0; ry = '0;
    unique case (st_r)
      ST_RED_A: begin rctl.start = (an_r != 0); rx = an_r; ry = ad_r; end
      ST_RED_B: begin rctl.start = (bn_r != 0); rx = bn_r; ry = bd_r; end
      ST_RED_R: begin rctl.start = (rn_r != 0 && rd_r != 0); rx = rn_r; ry = rd_r; end
      default: ;
    endcase
  end

  rau_reduce u_reduce (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (rctl),
    .x_in  (rx),
    .y_in  (ry),
    .sts   (rsts),
    .x_out (qx),
    .y_out (qy)
  );

  logic signed [64:0] sl, sr, sdiff;
  assign sl    = as_r ? -$signed({1'b0, p0_r}) : $signed({1'b0, p0_r});
  assign sr    = bs_r ? -$signed({1'b0, p1_r}) : $signed({1'b0, p1_r});
  assign sdiff = (act_r == ACT_SUB) ? (sl - sr) : (sl + sr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      unique case (st_r)
        ST_IDLE: if (in_valid) begin
          act_r <= in_action;
          an_r  <= op_mag(in_a_num);
          ad_r  <= op_mag(in_a_den);
          bn_r  <= op_mag(in_b_num);
          bd_r  <= op_mag(in_b_den);
          as_r  <= in_a_num[W-1] ^ in_a_den[W-1];
          bs_r  <= in_b_num[W-1] ^ in_b_den[W-1];
          // zero numerator or denominator gives 0/1
          if (op_mag(in_a_num) == 0 || op_mag(in_a_den) == 0) begin
            an_r <= '0; ad_r <= 64'd1; as_r <= 1'b0;
          end
          if (op_mag(in_b_num) == 0 || op_mag(in_b_den) == 0) begin
            bn_r <= '0; bd_r <= 64'd1; bs_r <= 1'b0;
          end
        end
        ST_WAIT_A: if (rsts.done) begin an_r <= qx; ad_r <= qy; end
        ST_WAIT_B: if (rsts.done) begin bn_r <= qx; bd_r <= qy; end
        ST_MUL1: p0_r <= mp;
        ST_MUL2: p1_r <= mp;
        ST_FORM: begin
          rn_r <= '0; rd_r <= 64'd1; rs_r <= 1'b0;
          lt_r <= 1'b0; eq_r <= 1'b0; gt_r <= 1'b0;
          case (act_r) inside
            ACT_ADD, ACT_SUB: begin
              rn_r <= sdiff[64] ? 64'(-sdiff) : sdiff[63:0];
              rs_r <= sdiff[64];
              rd_r <= mp;
            end
            ACT_MUL: begin
              rn_r <= p0_r; rs_r <= as_r ^ bs_r; rd_r <= mp;
            end
            ACT_DIV: if (bn_r != 0) begin
              // a / b = (an*bd) / (ad*bn)
              rn_r <= p0_r; rs_r <= as_r ^ bs_r; rd_r <= p1_r;
            end
            ACT_CMP: begin
              lt_r <= (sl < sr); eq_r <= (sl == sr); gt_r <= (sl > sr);
            end
            default: ;
          endcase
        end
        ST_RED_R: if (rn_r == 0 || rd_r == 0) begin
          rn_r <= '0; rd_r <= 64'd1; rs_r <= 1'b0;
        end
        ST_WAIT_R: if (rsts.done) begin rn_r <= qx; rd_r <= qy; end
        default: ;
      endcase
      out_valid_r <= (st_nxt == ST_OUT);
    end
  end

  assign in_stall       = (st_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_res_num    = rs_r ? -$signed(rn_r) : $signed(rn_r);
  assign out_res_den    = rd_r[61:0];
  assign out_is_less    = lt_r;
  assign out_is_equal   = eq_r;
  assign out_is_greater = gt_r;
endmodule
